// ----- design/bqc_pkg.sv -----
package bqc_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS        = 24;
  localparam int COEFF_BITS         = 32;
  localparam int SECTION_IDX_BITS   = 3;
  localparam int COEFF_SEL_BITS     = 3;
  localparam int ACTIVE_BITS        = 4;
  localparam int COEFFS_PER_SECTION = 5;

  // Product and accumulator widths: five full products plus rounding fit, with three guard bits
  localparam int PROD_W = COEFF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;

  // Action codes
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // Coefficient slots within one section, also the tap order of the sequencer
  localparam logic [COEFF_SEL_BITS-1:0] TAP_B0 = 3'd0;
  localparam logic [COEFF_SEL_BITS-1:0] TAP_B1 = 3'd1;
  localparam logic [COEFF_SEL_BITS-1:0] TAP_B2 = 3'd2;
  localparam logic [COEFF_SEL_BITS-1:0] TAP_A1 = 3'd3;
  localparam logic [COEFF_SEL_BITS-1:0] TAP_A2 = 3'd4;

  typedef struct packed {
    logic                               action;
    logic signed [SAMPLE_BITS-1:0]      sample_in;
    logic [SECTION_IDX_BITS-1:0]        section_index;
    logic [COEFF_SEL_BITS-1:0]          coeff_select;
    logic signed [COEFF_BITS-1:0]       coeff_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]      sample_out;
    logic                               saturated;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAPS,
    S_DRAIN,
    S_FINAL,
    S_EMIT
  } state_t;

endpackage

// ----- design/bqc_ram.sv -----
module bqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/biquad_cascade_iir_filter_core.sv -----
// Channel   Direction  Handshake              Beat
// --------  ---------  ---------------------  ---------------------------------
// in        input      in_valid / in_stall    in_beat_t: sample or coeff load
// out       output     out_valid / out_stall  out_beat_t: filtered sample
// cfg       input      cfg_valid / cfg_ready  active section count, 4 bits
//
// A coefficient load is written into the coefficient store without leaving
// the idle state. A sample passes through each active section in turn:
// each section issues five coefficient reads into the single shared
// multiplier, waits for the multiply/accumulate pipe to drain, then rounds,
// saturates and updates its history; the last section's result is handed off.
// Reset (rst, synchronous) clears the histories and sets one active section;
// coefficients are unknown until loaded. A stalled result sits in the output
// register while the next beat is taken; the block holds before handing off
// the following result until that one is gone.
module biquad_cascade_iir_filter_core
  import bqc_pkg::*;
#(
  parameter int MAX_SECTIONS    = 8,
  parameter int COEFF_FRAC_BITS = 28
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_beat_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ACTIVE_BITS-1:0] cfg_data
);

  localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int DEPTH  = MAX_SECTIONS * COEFFS_PER_SECTION;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic signed [ACC_W-1:0] ROUND_ACC = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  state_t state, state_next;

  logic [ACTIVE_BITS-1:0]        active;
  logic [SEC_W-1:0]              sec;
  logic [SEC_W-1:0]              n_last;
  logic [SEC_W-1:0]              n_last_next;
  logic [COEFF_SEL_BITS-1:0]     tap;
  logic                          m_valid;
  logic [COEFF_SEL_BITS-1:0]     m_tap;
  logic                          c_valid;
  logic [COEFF_SEL_BITS-1:0]     c_tap;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic                          sat_any;

  logic signed [SAMPLE_BITS-1:0] x1 [MAX_SECTIONS];
  logic signed [SAMPLE_BITS-1:0] x2 [MAX_SECTIONS];
  logic signed [SAMPLE_BITS-1:0] y1 [MAX_SECTIONS];
  logic signed [SAMPLE_BITS-1:0] y2 [MAX_SECTIONS];

  logic                          accept_filter;
  logic                          coeff_wr;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             rd_addr;
  logic [COEFF_BITS-1:0]         rd_data;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [ACC_W-1:0]       acc_sh;
  logic                          clip_hi;
  logic                          clip_lo;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          emit_fire;

  assign cfg_ready = 1'b1;

  // Coefficient store
  assign coeff_wr = in_valid && !in_stall && (in_data.action == ACT_LOAD) &&
                    (32'(in_data.section_index) < MAX_SECTIONS) &&
                    (32'(in_data.coeff_select) < COEFFS_PER_SECTION);
  assign wr_addr  = ADDR_W'(32'(in_data.section_index) * COEFFS_PER_SECTION +
                            32'(in_data.coeff_select));
  assign rd_addr  = ADDR_W'(32'(sec) * COEFFS_PER_SECTION + 32'(tap));

  bqc_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (DEPTH)
  ) u_coeff_ram (
    .clk     (clk),
    .wr_en   (coeff_wr),
    .wr_addr (wr_addr),
    .wr_data (in_data.coeff_value),
    .rd_en   (state == S_TAPS),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Clamp the section count to the range the block has
  always_comb begin
    if (active == '0) begin
      n_last_next = '0;
    end else if (32'(active) > MAX_SECTIONS) begin
      n_last_next = SEC_W'(MAX_SECTIONS - 1);
    end else begin
      n_last_next = SEC_W'(32'(active) - 1);
    end
  end

  // Pick the multiplier operand for the tap in the multiply stage
  always_comb begin
    case (m_tap)
      TAP_B0:  operand = x_cur;
      TAP_B1:  operand = x1[sec];
      TAP_B2:  operand = x2[sec];
      TAP_A1:  operand = y1[sec];
      TAP_A2:  operand = y2[sec];
      default: operand = '0;
    endcase
  end

  // Round, scale back and saturate the section sum
  assign acc_sh  = acc >>> COEFF_FRAC_BITS;
  assign clip_hi = acc_sh > Y_MAX;
  assign clip_lo = acc_sh < Y_MIN;
  always_comb begin
    if (clip_hi) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (clip_lo) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer: next state and handshake outputs
  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    accept_filter = 1'b0;
    emit_fire     = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_data.action == ACT_FILTER)) begin
          accept_filter = 1'b1;
          state_next    = S_TAPS;
        end
      end
      S_TAPS: begin
        if (tap == TAP_A2) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (c_valid && (c_tap == TAP_A2)) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        state_next = (sec == n_last) ? S_EMIT : S_TAPS;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit_fire  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers and section histories
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= ACTIVE_BITS'(1);
      sec       <= '0;
      n_last    <= '0;
      tap       <= TAP_B0;
      m_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        x1[i] <= '0;
        x2[i] <= '0;
        y1[i] <= '0;
        y2[i] <= '0;
      end
    end else begin
      state   <= state_next;
      m_valid <= (state == S_TAPS);
      c_valid <= m_valid;

      if (cfg_valid && cfg_ready) begin
        active <= cfg_data;
      end

      // Advance the section and tap counters
      if (accept_filter) begin
        sec    <= '0;
        tap    <= TAP_B0;
        n_last <= n_last_next;
      end else if (state == S_TAPS) begin
        tap <= tap + 3'd1;
      end else if (state == S_FINAL) begin
        tap <= TAP_B0;
        if (sec != n_last) begin
          sec <= sec + SEC_W'(1);
        end
      end

      // Shift the history of the finished section
      if (state == S_FINAL) begin
        x2[sec] <= x1[sec];
        x1[sec] <= x_cur;
        y2[sec] <= y1[sec];
        y1[sec] <= y_sat;
      end

      // Hold the result until taken
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Multiply/accumulate pipe and sample path
  always_ff @(posedge clk) begin
    m_tap <= tap;
    c_tap <= m_tap;
    prod  <= $signed(rd_data) * operand;

    if (accept_filter || (state == S_FINAL)) begin
      acc <= ROUND_ACC;
    end else if (c_valid) begin
      if ((c_tap == TAP_A1) || (c_tap == TAP_A2)) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end

    if (accept_filter) begin
      x_cur   <= in_data.sample_in;
      sat_any <= 1'b0;
    end else if (state == S_FINAL) begin
      x_cur   <= y_sat;
      sat_any <= sat_any | clip_hi | clip_lo;
    end

    if (emit_fire) begin
      out_data.sample_out <= x_cur;
      out_data.saturated  <= sat_any;
    end
  end

  // A result only appears from the hand-off state
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("out_valid rose outside the hand-off state");

  // The multiply stage only carries taps issued by the sequencer
  a_mul_issue: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> $past(state == S_TAPS))
    else $error("multiply stage valid without an issued tap");

  // The section counter never passes the last active section
  a_sec_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (sec <= n_last))
    else $error("section counter beyond last active section");

  // The accumulator pipe is empty when a section is rounded
  a_final_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> (!m_valid && !c_valid))
    else $error("section finished with products still in flight");

endmodule
